[hdl/tpg_pkg.sv]
`default_nettype none

package tpg_pkg;

  typedef enum logic [1:0] {
    OP_TICK = 2'd0,
    OP_MOVE = 2'd1,
    OP_JOG  = 2'd2,
    OP_SET  = 2'd3
  } op_t;

  localparam logic [1:0] CFG_SCALE_X      = 2'd0;
  localparam logic [1:0] CFG_SCALE_Y      = 2'd1;
  localparam logic [1:0] CFG_LIMIT_GATING = 2'd2;

  localparam logic [23:0] SCALE_X_RESET = 24'd5246350;  // ~27218/340 pulses per mm
  localparam logic [23:0] SCALE_Y_RESET = 24'd6382361;  // ~30190/310 pulses per mm

  // pulses = floor((target*scale + 50*2^16) / (100*2^16)), done as >>16 then /100
  localparam logic [40:0] ROUND_BIAS  = 41'd3276800;
  localparam logic [24:0] QUOT_SAT    = 25'd6553600;   // first value giving >= 65536 pulses
  localparam logic [23:0] RECIP_100   = 24'd10737419;  // ceil(2^30 / 100)
  localparam int          RECIP_SHIFT = 30;

  typedef struct packed {
    op_t         operation;
    logic [15:0] target_x;
    logic [15:0] target_y;
    logic [15:0] count_x;
    logic [15:0] count_y;
    logic        jog_dir_x;
    logic        jog_dir_y;
    logic        sw_x_min;
    logic        sw_x_max;
    logic        sw_y_min;
    logic        sw_y_max;
  } cmd_t;

  typedef struct packed {
    logic s1;  // load conversion stage 1
    logic s2;  // load conversion stage 2
  } pipe_adv_t;

endpackage

`default_nettype wire

[hdl/tpg_ifs.sv]
`default_nettype none

interface tpg_cmd_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [15:0] target_x;
  logic [15:0] target_y;
  logic [15:0] count_x;
  logic [15:0] count_y;
  logic        jog_dir_x;
  logic        jog_dir_y;
  logic        sw_x_min;
  logic        sw_x_max;
  logic        sw_y_min;
  logic        sw_y_max;

  modport source (
    output valid, operation, target_x, target_y, count_x, count_y,
           jog_dir_x, jog_dir_y, sw_x_min, sw_x_max, sw_y_min, sw_y_max,
    input  ready
  );
  modport sink (
    input  valid, operation, target_x, target_y, count_x, count_y,
           jog_dir_x, jog_dir_y, sw_x_min, sw_x_max, sw_y_min, sw_y_max,
    output ready
  );
endinterface

interface tpg_res_if;
  logic valid;
  logic ready;
  logic step_x;
  logic step_y;
  logic dir_x;
  logic dir_y;
  logic busy_res;
  logic done_res;
  logic rejected;

  modport source (
    output valid, step_x, step_y, dir_x, dir_y, busy_res, done_res, rejected,
    input  ready
  );
  modport sink (
    input  valid, step_x, step_y, dir_x, dir_y, busy_res, done_res, rejected,
    output ready
  );
endinterface

interface tpg_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [23:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

[hdl/tpg_conv.sv]
`default_nettype none

// Target in hundredths of mm to pulse count, two register stages.
module tpg_conv
  import tpg_pkg::*;
(
  input  wire logic        clk,
  input  wire pipe_adv_t   adv,
  input  wire logic [15:0] target,
  input  wire logic [23:0] scale,
  output logic      [15:0] pulses
);

  logic [39:0] prod;
  logic [40:0] biased;
  logic [24:0] quot;       // (target*scale + bias) >> 16
  logic [24:0] quot_next;
  logic [46:0] recip_prod;
  logic [15:0] pulses_next;

  assign prod      = 40'(target) * 40'(scale);
  assign biased    = 41'(prod) + ROUND_BIAS;
  assign quot_next = biased[40:16];

  // quot < 2^23 whenever not saturated, where the reciprocal is exact
  assign recip_prod  = 47'(quot[22:0]) * 47'(RECIP_100);
  assign pulses_next = (quot >= QUOT_SAT) ? 16'hFFFF
                                          : recip_prod[RECIP_SHIFT +: 16];

  always_ff @(posedge clk) begin
    if (adv.s1) begin
      quot <= quot_next;
    end
    if (adv.s2) begin
      pulses <= pulses_next;
    end
  end

endmodule

`default_nettype wire

[hdl/two_axis_step_pulse_generator_core.sv]
// Two-axis step/direction generator.
// Channels: cmd (sink) carries one operation per transfer: tick, absolute
// move, raw jog or set position. res (source) returns exactly one result per
// command, in order: step and direction pin levels, busy, done and rejected.
// cfg (sink) writes scale_x, scale_y and limit_gating by index; it is always
// ready and must only be used while no command is in flight.
// A command passes through the input register, two conversion stages and the
// result register before its result is valid on res.
// One command per clock while res is ready. The multiply by the scale and
// the reciprocal multiply for the divide by 100 are each one pipeline stage;
// position, counts and pins update in the last stage, so commands that
// follow each other back to back see each other's effects in order.
// When res stalls, the pipeline fills and cmd.ready drops once every stage
// holds an item; nothing is dropped. Synchronous reset clears the pipeline,
// the axis state (phases set to one), limit_gating and loads default scales.
`default_nettype none

module two_axis_step_pulse_generator_core
  import tpg_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  tpg_cmd_if.sink    cmd,
  tpg_res_if.source  res,
  tpg_cfg_if.sink    cfg
);

  logic [23:0] scale_x;
  logic [23:0] scale_y;
  logic        limit_gating;

  logic        v0, v1, v2, v3;
  cmd_t        c0, c1, c2;
  cmd_t        cmd_in;
  logic        r0, r1, r2, r3;
  pipe_adv_t   adv;
  logic [15:0] pulses_x, pulses_y;

  logic [15:0] position_x, position_y, remain_x, remain_y;
  logic        phase_x, phase_y, half_x, half_y, pin_x, pin_y;
  logic        direction_x, direction_y, running;

  logic [15:0] position_x_next, position_y_next, remain_x_next, remain_y_next;
  logic        phase_x_next, phase_y_next, half_x_next, half_y_next;
  logic        pin_x_next, pin_y_next, direction_x_next, direction_y_next;
  logic        running_next, done_next, rej_next;
  logic        step_go;

  // ready chain: each stage takes a new item when empty or moving on
  assign r3 = !v3 || res.ready;
  assign r2 = !v2 || r3;
  assign r1 = !v1 || r2;
  assign r0 = !v0 || r1;
  assign cmd.ready = r0;
  assign cfg.ready = 1'b1;

  assign adv.s1 = r1;
  assign adv.s2 = r2;

  assign cmd_in = '{
    operation: op_t'(cmd.operation),
    target_x:  cmd.target_x,
    target_y:  cmd.target_y,
    count_x:   cmd.count_x,
    count_y:   cmd.count_y,
    jog_dir_x: cmd.jog_dir_x,
    jog_dir_y: cmd.jog_dir_y,
    sw_x_min:  cmd.sw_x_min,
    sw_x_max:  cmd.sw_x_max,
    sw_y_min:  cmd.sw_y_min,
    sw_y_max:  cmd.sw_y_max
  };

  tpg_conv u_conv_x (
    .clk    (clk),
    .adv    (adv),
    .target (c0.target_x),
    .scale  (scale_x),
    .pulses (pulses_x)
  );

  tpg_conv u_conv_y (
    .clk    (clk),
    .adv    (adv),
    .target (c0.target_y),
    .scale  (scale_y),
    .pulses (pulses_y)
  );

  assign step_go = !limit_gating
                || (c2.sw_x_min && c2.sw_x_max && c2.sw_y_min && c2.sw_y_max);

  always_comb begin
    position_x_next  = position_x;
    position_y_next  = position_y;
    remain_x_next    = remain_x;
    remain_y_next    = remain_y;
    phase_x_next     = phase_x;
    phase_y_next     = phase_y;
    half_x_next      = half_x;
    half_y_next      = half_y;
    pin_x_next       = pin_x;
    pin_y_next       = pin_y;
    direction_x_next = direction_x;
    direction_y_next = direction_y;
    running_next     = running;
    done_next        = 1'b0;
    rej_next         = 1'b0;

    unique case (c2.operation)
      OP_TICK: begin
        if (step_go && remain_x != 16'd0) begin
          pin_x_next   = phase_x;
          phase_x_next = ~phase_x;
          half_x_next  = ~half_x;
          if (half_x) begin
            remain_x_next = remain_x - 16'd1;
          end
        end
        if (step_go && remain_y != 16'd0) begin
          pin_y_next   = phase_y;
          phase_y_next = ~phase_y;
          half_y_next  = ~half_y;
          if (half_y) begin
            remain_y_next = remain_y - 16'd1;
          end
        end
        if (running && remain_x_next == 16'd0 && remain_y_next == 16'd0) begin
          running_next = 1'b0;
          done_next    = 1'b1;
        end
      end
      OP_MOVE: begin
        if (running) begin
          rej_next = 1'b1;
        end else begin
          if (pulses_x >= position_x) begin
            direction_x_next = 1'b1;
            remain_x_next    = pulses_x - position_x;
          end else begin
            direction_x_next = 1'b0;
            remain_x_next    = position_x - pulses_x;
          end
          if (pulses_y >= position_y) begin
            direction_y_next = 1'b1;
            remain_y_next    = pulses_y - position_y;
          end else begin
            direction_y_next = 1'b0;
            remain_y_next    = position_y - pulses_y;
          end
          position_x_next = pulses_x;
          position_y_next = pulses_y;
          running_next    = 1'b1;
        end
      end
      OP_JOG: begin
        if (running) begin
          rej_next = 1'b1;
        end else begin
          remain_x_next    = c2.count_x;
          remain_y_next    = c2.count_y;
          direction_x_next = c2.jog_dir_x;
          direction_y_next = c2.jog_dir_y;
          running_next     = 1'b1;
        end
      end
      OP_SET: begin
        position_x_next = c2.count_x;
        position_y_next = c2.count_y;
      end
      default: begin
      end
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      scale_x      <= SCALE_X_RESET;
      scale_y      <= SCALE_Y_RESET;
      limit_gating <= 1'b0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CFG_SCALE_X:      scale_x      <= cfg.data;
        CFG_SCALE_Y:      scale_y      <= cfg.data;
        CFG_LIMIT_GATING: limit_gating <= cfg.data[0];
        default: begin
        end
      endcase
    end
  end

  // pipeline valids and axis state
  always_ff @(posedge clk) begin
    if (rst) begin
      v0          <= 1'b0;
      v1          <= 1'b0;
      v2          <= 1'b0;
      v3          <= 1'b0;
      position_x  <= '0;
      position_y  <= '0;
      remain_x    <= '0;
      remain_y    <= '0;
      phase_x     <= 1'b1;
      phase_y     <= 1'b1;
      half_x      <= 1'b0;
      half_y      <= 1'b0;
      pin_x       <= 1'b0;
      pin_y       <= 1'b0;
      direction_x <= 1'b0;
      direction_y <= 1'b0;
      running     <= 1'b0;
    end else begin
      if (r0) begin
        v0 <= cmd.valid;
      end
      if (r1) begin
        v1 <= v0;
      end
      if (r2) begin
        v2 <= v1;
      end
      if (r3) begin
        v3 <= v2;
      end
      if (r3 && v2) begin
        position_x  <= position_x_next;
        position_y  <= position_y_next;
        remain_x    <= remain_x_next;
        remain_y    <= remain_y_next;
        phase_x     <= phase_x_next;
        phase_y     <= phase_y_next;
        half_x      <= half_x_next;
        half_y      <= half_y_next;
        pin_x       <= pin_x_next;
        pin_y       <= pin_y_next;
        direction_x <= direction_x_next;
        direction_y <= direction_y_next;
        running     <= running_next;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (r0) begin
      c0 <= cmd_in;
    end
    if (r1) begin
      c1 <= c0;
    end
    if (r2) begin
      c2 <= c1;
    end
    if (r3) begin
      res.step_x   <= pin_x_next;
      res.step_y   <= pin_y_next;
      res.dir_x    <= direction_x_next;
      res.dir_y    <= direction_y_next;
      res.busy_res <= running_next;
      res.done_res <= done_next;
      res.rejected <= rej_next;
    end
  end

  assign res.valid = v3;

endmodule

`default_nettype wire
